// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sss_pkg.sv =====
// Shared types and constants for the stack store with search.
package sss_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int VALUE_W    = 32;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 5;
    localparam int FILL_W     = 5;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    push;
        logic    pop;
        logic    scan_start;
        logic    scan_rd;
        logic    res_we;
        t_status res_status;
        logic    res_found;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic is_search;
        logic full;
        logic empty;
        logic match;
        logic scan_end;
    } t_stat;

endpackage

// ===== sv/sss_ctrl.sv =====
// Command sequencer: handshakes and per-command control of the datapath.
module sss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  sss_pkg::t_stat i_stat,
    output sss_pkg::t_cmd  o_cmd
);
    import sss_pkg::*;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state              = r_state;
        o_s_tready           = 1'b0;
        o_cmd.load           = 1'b0;
        o_cmd.push           = 1'b0;
        o_cmd.pop            = 1'b0;
        o_cmd.scan_start     = 1'b0;
        o_cmd.scan_rd        = 1'b0;
        o_cmd.res_we         = 1'b0;
        o_cmd.res_status     = STAT_OK;
        o_cmd.res_found      = 1'b0;
        o_cmd.out_load       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state      = S_DONE;
                o_cmd.res_we = 1'b1;
                priority if (i_stat.is_push) begin
                    if (i_stat.full) begin
                        o_cmd.res_status = STAT_FULL;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_stat.is_pop) begin
                    if (i_stat.empty) begin
                        o_cmd.res_status = STAT_EMPTY;
                    end else begin
                        o_cmd.pop = 1'b1;
                    end
                end else if (i_stat.is_search) begin
                    if (i_stat.empty) begin
                        o_cmd.res_status = STAT_EMPTY;
                    end else begin
                        o_cmd.res_we     = 1'b0;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end else begin
                    // unused opcode: no state change, plain ok
                    o_cmd.res_status = STAT_OK;
                end
            end
            S_SCAN: begin
                // read of entry k overlaps the compare of entry k-1
                if (i_stat.match) begin
                    o_cmd.res_we    = 1'b1;
                    o_cmd.res_found = 1'b1;
                    n_state         = S_DONE;
                end else if (i_stat.scan_end) begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = STAT_NOT_FOUND;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    assign o_m_tvalid = r_m_valid;

endmodule

// ===== sv/sss_dpath.sv =====
// Datapath: entry memory, count, scan pointer, compare and result registers.
module sss_dpath #(
    parameter int DEPTH      = sss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = sss_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sss_pkg::t_cmd                  i_cmd,
    output sss_pkg::t_stat                 o_stat,
    input  logic [sss_pkg::VALUE_W-1:0]    i_s_tdata,
    input  logic [sss_pkg::OP_W-1:0]       i_s_tuser,
    output logic [sss_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [sss_pkg::STATUS_W-1:0]   o_m_tuser
);
    import sss_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int PW = (CW + 1 > POS_W) ? CW + 1 : POS_W;
    localparam int FW = (CW > FILL_W) ? CW : FILL_W;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [OP_W-1:0]       r_op;
    logic [DATA_WIDTH-1:0] r_value;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_scan_idx;
    logic [CW-1:0]         r_rd_idx;
    logic                  r_rd_valid;
    logic [DATA_WIDTH-1:0] r_rd_data;
    t_status               r_res_status;
    logic [POS_W-1:0]      r_res_pos;
    logic [OUT_DATA_W-1:0] r_out_tdata;
    logic [STATUS_W-1:0]   r_out_tuser;

    logic [XW-1:0]         value_ext;
    logic                  rd_en;
    logic [PW-1:0]         pos_ext;
    logic [FW-1:0]         fill_ext;

    // sign-extend or truncate the 32-bit field to the stored width
    assign value_ext = XW'(signed'(i_s_tdata));
    assign rd_en     = i_cmd.scan_rd && (r_scan_idx < r_count);
    assign pos_ext   = PW'(r_rd_idx) + PW'(1);
    assign fill_ext  = FW'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_s_tuser;
            r_value <= value_ext[DATA_WIDTH-1:0];
        end
        if (i_cmd.push) begin
            r_mem[r_count[AW-1:0]] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_scan_idx[AW-1:0]];
            r_rd_idx  <= r_scan_idx;
        end
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_rd) begin
            r_scan_idx <= r_scan_idx + CW'(1);
        end
        if (i_cmd.res_we) begin
            r_res_status <= i_cmd.res_status;
            r_res_pos    <= i_cmd.res_found ? pos_ext[POS_W-1:0] : '0;
        end
        if (i_cmd.out_load) begin
            r_out_tuser <= r_res_status;
            r_out_tdata <= OUT_DATA_W'({fill_ext[FILL_W-1:0], r_res_pos});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_rd_valid <= 1'b0;
            end else if (i_cmd.scan_rd) begin
                r_rd_valid <= rd_en;
            end
        end
    end

    assign o_stat.is_push   = (r_op == OP_PUSH);
    assign o_stat.is_pop    = (r_op == OP_POP);
    assign o_stat.is_search = (r_op == OP_SEARCH);
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.match     = r_rd_valid && (r_rd_data == r_value);
    assign o_stat.scan_end  = r_rd_valid && ((r_rd_idx + CW'(1)) == r_count);

    assign o_m_tdata = r_out_tdata;
    assign o_m_tuser = r_out_tuser;

endmodule

// ===== sv/stack_store_with_search_core.sv =====
// Bounded stack of signed values with push, pop and oldest-first search.
// Commands are taken one at a time. Push, pop and the unused opcode pass
// through the execute and done states before the next accept; a search
// also scans the entries oldest first until the first match or the last
// entry. The entry memory has a single registered read port and the
// scan reads one entry per cycle. The result sits in an output register, so
// a new command is taken while the previous result still waits on the
// master side. Stored entries carry DATA_WIDTH bits; the 32-bit input value
// is sign-extended or truncated to that width for store and compare.
module stack_store_with_search_core #(
    parameter int DEPTH      = sss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = sss_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [sss_pkg::VALUE_W-1:0]    i_s_tdata,   // [31:0] value
    input  logic [sss_pkg::OP_W-1:0]       i_s_tuser,   // [1:0] op
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [sss_pkg::OUT_DATA_W-1:0] o_m_tdata,   // [4:0] position, [9:5] fill_count
    output logic [sss_pkg::STATUS_W-1:0]   o_m_tuser    // [1:0] status
);
    import sss_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sss_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

endmodule

// ===== sv/sss_checker.sv =====
// Port-level checks for the stack store core, bound to the top level.
`include "assert_macros.svh"

module sss_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [sss_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [sss_pkg::STATUS_W-1:0]   o_m_tuser
);
    import sss_pkg::*;

    logic s_acc;
    logic m_stall;
    logic res_empty;
    logic res_fail;
    logic res_zero;
    logic pos_zero;

    assign s_acc     = i_s_tvalid && o_s_tready;
    assign m_stall   = o_m_tvalid && !i_m_tready;
    assign res_empty = o_m_tvalid && (o_m_tuser == STAT_EMPTY);
    assign res_fail  = o_m_tvalid && ((o_m_tuser == STAT_FULL) || (o_m_tuser == STAT_NOT_FOUND));
    assign res_zero  = (o_m_tdata[POS_W+FILL_W-1:0] == '0);
    assign pos_zero  = (o_m_tdata[POS_W-1:0] == '0);

    // result must wait for the consumer
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_stall |=> o_m_tvalid, "result dropped on stall")

    // one command in flight: no accept right after an accept
    `ASSERT_CLK(a_one_cmd, i_clk, i_rst_n, s_acc |=> !o_s_tready, "ready after transaction")

    // empty result carries no position and no entries
    `ASSERT_CLK(a_empty_zero, i_clk, i_rst_n, res_empty |-> res_zero, "empty with fields set")

    // only a found search reports a position
    `ASSERT_CLK(a_pos_zero, i_clk, i_rst_n, res_fail |-> pos_zero, "position on failed command")

    `ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind stack_store_with_search_core sss_checker u_sss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== dv/stack_store_with_search_checker.sv =====
// Scoreboard for the stack store with search: predicts each command's result and compares.
module stack_store_with_search_checker
    import sss_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [VALUE_W-1:0]    i_s_tdata,    // [31:0] value
    input  logic [OP_W-1:0]       i_s_tuser,    // [1:0] op
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,    // [4:0] position, [9:5] fill_count
    input  logic [STATUS_W-1:0]   i_m_tuser,    // [1:0] status
    output int                    o_err_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  position;
        logic [FILL_W-1:0] fill;
    } t_result;

    t_word       stack_words[DEPTH];
    int unsigned stack_depth;
    t_result     result_q[$];
    int          errs;

    function automatic t_result run_command(input logic [OP_W-1:0]    op,
                                            input logic [VALUE_W-1:0] value);
        t_result     r;
        t_word       key;
        int unsigned i;
        bit          hit;
        key        = t_word'($signed(value));
        r.status   = STAT_OK;
        r.position = '0;
        hit        = 1'b0;
        case (op)
            OP_PUSH: begin
                if (stack_depth >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    stack_words[stack_depth] = key;
                    stack_depth++;
                end
            end
            OP_POP: begin
                if (stack_depth == 0) r.status = STAT_EMPTY;
                else stack_depth--;
            end
            OP_SEARCH: begin
                if (stack_depth == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    // oldest entry first, first match wins
                    r.status = STAT_NOT_FOUND;
                    for (i = 0; i < stack_depth && !hit; i++) begin
                        if (stack_words[i] == key) begin
                            r.status   = STAT_OK;
                            r.position = POS_W'(i + 1);
                            hit        = 1'b1;
                        end
                    end
                end
            end
            default: ;  // unused opcode: no state change
        endcase
        r.fill = FILL_W'(stack_depth);
        return r;
    endfunction

    function automatic void flag_error(input string msg);
        errs++;
        if (errs <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        t_result                        want;
        logic [POS_W-1:0]               got_pos;
        logic [FILL_W-1:0]              got_fill;
        logic [OUT_DATA_W-POS_W-FILL_W-1:0] got_pad;
        if (!i_rst_n) begin
            stack_depth = 0;
            errs        = 0;
            result_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) result_q.push_back(run_command(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got_pos  = i_m_tdata[POS_W-1:0];
                got_fill = i_m_tdata[POS_W +: FILL_W];
                got_pad  = i_m_tdata[OUT_DATA_W-1:POS_W+FILL_W];
                if (result_q.size() == 0) begin
                    flag_error($sformatf("unexpected result: status %0d pos %0d fill %0d",
                                         i_m_tuser, got_pos, got_fill));
                end else begin
                    want = result_q.pop_front();
                    if (i_m_tuser !== want.status || got_pos !== want.position ||
                        got_fill !== want.fill || got_pad !== '0) begin
                        flag_error($sformatf({"result mismatch: expected status %0d pos %0d ",
                                              "fill %0d, got status %0d pos %0d fill %0d pad %h"},
                                             want.status, want.position, want.fill,
                                             i_m_tuser, got_pos, got_fill, got_pad));
                    end
                end
            end
        end
        o_err_count <= errs;
        o_pending   <= result_q.size();
    end

endmodule

// ===== dv/tb_stack_store_with_search_core.sv =====
// Testbench top for the stack store with search: stimulus, handshake pressure and verdict.
module tb_stack_store_with_search_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sss_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              N_CMDS    = 1400;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata  = '0;   // [31:0] value
    logic [OP_W-1:0]       s_tuser  = '0;   // [1:0] op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [4:0] position, [9:5] fill_count
    logic [STATUS_W-1:0]   m_tuser;         // [1:0] status

    int err_count;
    int pending;
    int burst_left;
    logic [VALUE_W-1:0] value_pool[8];

    stack_store_with_search_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    stack_store_with_search_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("tb_stack_store_with_search_core: FAIL");
        $finish;
    end

    // Result side: random stall modes, plus two long hold-offs that back up the input.
    initial begin : result_sink
        int cyc;
        int mode;
        int span;
        cyc = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(posedge clk);
                cyc++;
                if (cyc == 2000 || cyc == 15000) begin
                    m_tready <= 1'b0;
                    repeat (300) @(posedge clk);
                    cyc += 300;
                end else begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= $urandom_range(0, 1);
                        2: m_tready <= ($urandom_range(0, 9) < 8);
                        default: m_tready <= ($urandom_range(0, 9) < 2);
                    endcase
                end
            end
        end
    end

    // One command transaction; afterwards either stay in the burst or take a gap.
    task automatic issue(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Mostly pool values so searches hit and duplicates occur.
    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    initial begin : stimulus
        logic [VALUE_W-1:0] last_val;
        logic [OP_W-1:0]    op;
        int                 sent;
        int                 phase_left;
        int                 roll;
        bit                 fill_phase;

        burst_left = 0;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int k = 2; k < 8; k++) value_pool[k] = $urandom();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-store cases
        issue(OP_POP, $urandom());
        issue(OP_SEARCH, '0);
        issue(OP_UNUSED, $urandom());
        // extremes, with a duplicate of the most negative value
        issue(OP_PUSH, 32'h8000_0000);
        issue(OP_PUSH, 32'h7FFF_FFFF);
        issue(OP_PUSH, 32'h0000_0000);
        issue(OP_PUSH, 32'hFFFF_FFFF);
        issue(OP_PUSH, 32'h8000_0000);
        issue(OP_SEARCH, 32'h8000_0000);
        issue(OP_SEARCH, 32'hFFFF_FFFF);
        issue(OP_UNUSED, $urandom());
        for (int k = 0; k < 11; k++) begin
            last_val = $urandom();
            issue(OP_PUSH, last_val);
        end
        issue(OP_PUSH, $urandom());          // store full
        issue(OP_SEARCH, last_val);          // match in the last slot
        issue(OP_SEARCH, 32'h5A5A_A5A5);     // full scan, no match
        issue(OP_POP, $urandom());
        drain();

        sent       = 0;
        fill_phase = 1'b1;
        phase_left = $urandom_range(20, 60);
        while (sent < N_CMDS) begin
            if (phase_left == 0) begin
                fill_phase = !fill_phase;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            if ($urandom_range(0, 99) == 0) value_pool[$urandom_range(2, 7)] = $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 4) op = OP_UNUSED;
            else if (roll < 40) op = fill_phase ? OP_PUSH : OP_POP;
            else if (roll < 55) op = fill_phase ? OP_POP : OP_PUSH;
            else op = OP_SEARCH;
            issue(op, (op == OP_PUSH || op == OP_SEARCH) ? pick_value() : $urandom());
            if (op != OP_UNUSED) begin
                sent++;
                if (sent == N_CMDS / 2) drain();
            end
        end

        drain();
        repeat (30) @(posedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("tb_stack_store_with_search_core: PASS");
        end else begin
            $display("tb_stack_store_with_search_core: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sss_pkg.sv
sv/sss_ctrl.sv
sv/sss_dpath.sv
sv/stack_store_with_search_core.sv
sv/sss_checker.sv
dv/stack_store_with_search_checker.sv
dv/tb_stack_store_with_search_core.sv
